// ----- design/rwl_pkg.sv -----
// Shared types and constants for the readers-writer lock arbiter.
// No dependencies; every other design file uses this package.
package rwl_pkg;

  localparam int QUEUE_DEPTH = 16;
  localparam int MAX_THREADS = 16;
  localparam int READER_MAX  = 31;
  localparam int RESULT_MAX  = 16;

  localparam int MODE_W   = 2;
  localparam int ID_W     = 4;
  localparam int EVENT_W  = 3;
  localparam int READER_W = 5;
  localparam int QPTR_W   = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CNT_W    = $clog2(QUEUE_DEPTH + 1);
  localparam int WAKE_W   = $clog2(RESULT_MAX);

  // request modes as they arrive on the input channel
  localparam logic [MODE_W-1:0] MODE_ENTER_READ  = 2'd0;
  localparam logic [MODE_W-1:0] MODE_ENTER_WRITE = 2'd1;
  localparam logic [MODE_W-1:0] MODE_EXIT_READ   = 2'd2;
  localparam logic [MODE_W-1:0] MODE_EXIT_WRITE  = 2'd3;

  // result event codes
  localparam logic [EVENT_W-1:0] EV_READ_GRANT   = 3'd0;
  localparam logic [EVENT_W-1:0] EV_WRITE_GRANT  = 3'd1;
  localparam logic [EVENT_W-1:0] EV_QUEUED       = 3'd2;
  localparam logic [EVENT_W-1:0] EV_RELEASED     = 3'd3;
  localparam logic [EVENT_W-1:0] EV_READER_WOKEN = 3'd4;
  localparam logic [EVENT_W-1:0] EV_WRITER_WOKEN = 3'd5;
  localparam logic [EVENT_W-1:0] EV_ERROR        = 3'd6;

  // classified operation handed from front to back
  typedef enum logic [2:0] {
    OP_ENTER_READ,
    OP_ENTER_WRITE,
    OP_EXIT_READ,
    OP_EXIT_WRITE,
    OP_BAD_ID
  } op_t;

  typedef struct packed {
    op_t             op;
    logic [ID_W-1:0] id;
  } item_t;

  typedef enum logic {
    ST_IDLE,
    ST_WAKE
  } back_state_t;

endpackage

// ----- design/rwl_req_if.sv -----
// Request channel: valid/ready handshake carrying mode and requester id.
// Depends on rwl_pkg for field widths.
interface rwl_req_if;
  logic                       valid;
  logic                       ready;
  logic [rwl_pkg::MODE_W-1:0] mode;
  logic [rwl_pkg::ID_W-1:0]   requester_id;

  modport source (output valid, output mode, output requester_id, input ready);
  modport sink   (input valid, input mode, input requester_id, output ready);
endinterface

// ----- design/rwl_res_if.sv -----
// Result channel: valid/ready handshake carrying thread id, event and last flag.
// Depends on rwl_pkg for field widths.
interface rwl_res_if;
  logic                        valid;
  logic                        ready;
  logic [rwl_pkg::ID_W-1:0]    thread_id;
  logic [rwl_pkg::EVENT_W-1:0] event_res;
  logic                        last;

  modport source (output valid, output thread_id, output event_res, output last,
                  input ready);
  modport sink   (input valid, input thread_id, input event_res, input last,
                  output ready);
endinterface

// ----- design/rwl_front.sv -----
// Front end: accepts requests, classifies them and holds them in a two-entry queue.
// Depends on rwl_pkg and rwl_req_if.
module rwl_front (
  input  logic           clk,
  input  logic           rst,
  rwl_req_if.sink        req,
  output logic           q_valid,
  output rwl_pkg::item_t q_item,
  input  logic           q_pop
);
  import rwl_pkg::*;

  item_t      slot [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] count;
  logic       push;
  item_t      cls;

  // classify the incoming request
  always_comb begin
    cls.id = req.requester_id;
    if (32'(req.requester_id) >= MAX_THREADS) begin
      cls.op = OP_BAD_ID;
    end else begin
      case (req.mode)
        MODE_ENTER_READ:  cls.op = OP_ENTER_READ;
        MODE_ENTER_WRITE: cls.op = OP_ENTER_WRITE;
        MODE_EXIT_READ:   cls.op = OP_EXIT_READ;
        default:          cls.op = OP_EXIT_WRITE;
      endcase
    end
  end

  assign req.ready = (count != 2'd2);
  assign push      = req.valid && req.ready;
  assign q_valid   = (count != 2'd0);
  assign q_item    = slot[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      slot[wr_ptr] <= cls;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr <= ~wr_ptr;
      end
      if (q_pop) begin
        rd_ptr <= ~rd_ptr;
      end
      case ({push, q_pop})
        2'b10:   count <= count + 2'd1;
        2'b01:   count <= count - 2'd1;
        default: count <= count;
      endcase
    end
  end

endmodule

// ----- design/rwl_back.sv -----
// Back end: lock state, reader and writer wait queues, wake sequencer, result register.
// Depends on rwl_pkg and rwl_res_if.
module rwl_back (
  input  logic           clk,
  input  logic           rst,
  input  logic           q_valid,
  input  rwl_pkg::item_t q_item,
  output logic           q_pop,
  rwl_res_if.source      res
);
  import rwl_pkg::*;

  back_state_t         state, state_next;
  logic [READER_W-1:0] active_readers, active_readers_next;
  logic                writer_holds, writer_holds_next;
  logic [WAKE_W-1:0]   wake_cnt, wake_cnt_next;

  // wait queues: memories with registered read of the head entry
  logic [ID_W-1:0]     r_mem [QUEUE_DEPTH];
  logic [ID_W-1:0]     w_mem [QUEUE_DEPTH];
  logic [QPTR_W-1:0]   r_head, r_head_next, w_head, w_head_next;
  logic [CNT_W-1:0]    r_count, r_count_next, w_count, w_count_next;
  logic [ID_W-1:0]     r_rdata, w_rdata;
  logic                r_we, w_we, r_pop, w_pop;
  logic [QPTR_W-1:0]   r_waddr, w_waddr;

  // result register
  logic                res_valid;
  logic [ID_W-1:0]     res_id;
  logic [EVENT_W-1:0]  res_ev;
  logic                res_last;
  logic                load;
  logic [ID_W-1:0]     load_id;
  logic [EVENT_W-1:0]  load_ev;
  logic                load_last;
  logic                slot_free;

  assign slot_free     = !res_valid || res.ready;
  assign res.valid     = res_valid;
  assign res.thread_id = res_id;
  assign res.event_res = res_ev;
  assign res.last      = res_last;

  function automatic logic [QPTR_W-1:0] tail_addr(input logic [QPTR_W-1:0] head,
                                                  input logic [CNT_W-1:0] cnt);
    logic [CNT_W:0] sum;
    sum = (CNT_W + 1)'(head) + (CNT_W + 1)'(cnt);
    if (sum >= (CNT_W + 1)'(QUEUE_DEPTH)) begin
      sum = sum - (CNT_W + 1)'(QUEUE_DEPTH);
    end
    return sum[QPTR_W-1:0];
  endfunction

  function automatic logic [QPTR_W-1:0] ptr_inc(input logic [QPTR_W-1:0] p);
    if (32'(p) == QUEUE_DEPTH - 1) begin
      return '0;
    end
    return p + QPTR_W'(1);
  endfunction

  assign r_waddr     = tail_addr(r_head, r_count);
  assign w_waddr     = tail_addr(w_head, w_count);
  assign r_head_next = r_pop ? ptr_inc(r_head) : r_head;
  assign w_head_next = w_pop ? ptr_inc(w_head) : w_head;

  always_comb begin
    state_next          = state;
    active_readers_next = active_readers;
    writer_holds_next   = writer_holds;
    wake_cnt_next       = wake_cnt;
    r_count_next        = r_count;
    w_count_next        = w_count;
    r_we                = 1'b0;
    w_we                = 1'b0;
    r_pop               = 1'b0;
    w_pop               = 1'b0;
    q_pop               = 1'b0;
    load                = 1'b0;
    load_id             = q_item.id;
    load_ev             = EV_ERROR;
    load_last           = 1'b1;
    case (state)
      ST_IDLE: begin
        if (q_valid && slot_free) begin
          q_pop = 1'b1;
          load  = 1'b1;
          case (q_item.op)
            OP_ENTER_READ: begin
              if (!writer_holds && w_count == '0) begin
                if (32'(active_readers) >= READER_MAX) begin
                  load_ev = EV_ERROR;
                end else begin
                  active_readers_next = active_readers + READER_W'(1);
                  load_ev             = EV_READ_GRANT;
                end
              end else if (32'(r_count) >= QUEUE_DEPTH) begin
                load_ev = EV_ERROR;
              end else begin
                r_we         = 1'b1;
                r_count_next = r_count + CNT_W'(1);
                load_ev      = EV_QUEUED;
              end
            end
            OP_ENTER_WRITE: begin
              if (active_readers == '0 && !writer_holds) begin
                writer_holds_next = 1'b1;
                load_ev           = EV_WRITE_GRANT;
              end else if (32'(w_count) >= QUEUE_DEPTH) begin
                load_ev = EV_ERROR;
              end else begin
                w_we         = 1'b1;
                w_count_next = w_count + CNT_W'(1);
                load_ev      = EV_QUEUED;
              end
            end
            OP_EXIT_READ: begin
              if (active_readers == '0) begin
                load_ev = EV_ERROR;
              end else begin
                active_readers_next = active_readers - READER_W'(1);
                if (active_readers == READER_W'(1) && w_count != '0) begin
                  // last reader out: hand the lock to the oldest writer
                  w_pop             = 1'b1;
                  w_count_next      = w_count - CNT_W'(1);
                  writer_holds_next = 1'b1;
                  load_id           = w_rdata;
                  load_ev           = EV_WRITER_WOKEN;
                end else begin
                  load_ev = EV_RELEASED;
                end
              end
            end
            OP_EXIT_WRITE: begin
              if (!writer_holds) begin
                load_ev = EV_ERROR;
              end else begin
                writer_holds_next = 1'b0;
                if (r_count != '0) begin
                  // drain waiting readers one result per cycle while the result register is free
                  load          = 1'b0;
                  wake_cnt_next = '0;
                  state_next    = ST_WAKE;
                end else if (w_count != '0) begin
                  w_pop             = 1'b1;
                  w_count_next      = w_count - CNT_W'(1);
                  writer_holds_next = 1'b1;
                  load_id           = w_rdata;
                  load_ev           = EV_WRITER_WOKEN;
                end else begin
                  load_ev = EV_RELEASED;
                end
              end
            end
            default: begin
              load_ev = EV_ERROR;
            end
          endcase
        end
      end
      ST_WAKE: begin
        if (slot_free) begin
          load                = 1'b1;
          r_pop               = 1'b1;
          r_count_next        = r_count - CNT_W'(1);
          active_readers_next = active_readers + READER_W'(1);
          wake_cnt_next       = wake_cnt + WAKE_W'(1);
          load_id             = r_rdata;
          load_ev             = EV_READER_WOKEN;
          load_last           = (r_count == CNT_W'(1)) ||
                                (32'(wake_cnt) == RESULT_MAX - 1) ||
                                (32'(active_readers) + 1 >= READER_MAX);
          if (load_last) begin
            state_next = ST_IDLE;
          end
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  // queue memories; bypass a write to the next head so the read register stays current
  always_ff @(posedge clk) begin
    if (r_we) begin
      r_mem[r_waddr] <= q_item.id;
    end
    if (r_we && r_waddr == r_head_next) begin
      r_rdata <= q_item.id;
    end else begin
      r_rdata <= r_mem[r_head_next];
    end
  end

  always_ff @(posedge clk) begin
    if (w_we) begin
      w_mem[w_waddr] <= q_item.id;
    end
    if (w_we && w_waddr == w_head_next) begin
      w_rdata <= q_item.id;
    end else begin
      w_rdata <= w_mem[w_head_next];
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      res_id   <= load_id;
      res_ev   <= load_ev;
      res_last <= load_last;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state          <= ST_IDLE;
      active_readers <= '0;
      writer_holds   <= 1'b0;
      wake_cnt       <= '0;
      r_head         <= '0;
      r_count        <= '0;
      w_head         <= '0;
      w_count        <= '0;
      res_valid      <= 1'b0;
    end else begin
      state          <= state_next;
      active_readers <= active_readers_next;
      writer_holds   <= writer_holds_next;
      wake_cnt       <= wake_cnt_next;
      r_head         <= r_head_next;
      r_count        <= r_count_next;
      w_head         <= w_head_next;
      w_count        <= w_count_next;
      if (load) begin
        res_valid <= 1'b1;
      end else if (res.ready) begin
        res_valid <= 1'b0;
      end
    end
  end

endmodule

// ----- design/readers_writer_lock_arbiter_top.sv -----
// Top level of the readers-writer lock arbiter (writer preference).
// Depends on rwl_pkg, rwl_req_if, rwl_res_if, rwl_front and rwl_back.
//
//   req  - request channel (valid/ready). Each transfer carries mode (enter read,
//          enter write, exit read, exit write) and requester_id.
//   res  - result channel (valid/ready). Each transfer carries thread_id,
//          event_res and last; last marks the final result of a request.
//   A two-entry queue in the front end takes requests; the back end keeps the
//   lock state and the reader and writer wait queues and fills one output
//   register, so requests keep being taken while a result waits.
//   A request is written into the front queue; the back end pops it and loads
//   its result into the result register once that register is free. Throughput:
//   one request per cycle when it makes a single result and the receiver keeps
//   up. An exit write that wakes k waiting readers (k up to 16) decides, then the
//   wake sequencer pops them one entry a cycle while the result register is free.
//   Reset (rst, synchronous, active high) empties both queues, clears the
//   reader count and writer flag and drops any pending result. The wait
//   queue memories need no clearing pass.
//   Receiver stall: hold the result register; the back end waits, the front
//   queue fills and then req.ready drops. No result is lost or repeated.
module readers_writer_lock_arbiter_top (
  input  logic      clk,
  input  logic      rst,
  rwl_req_if.sink   req,
  rwl_res_if.source res
);
  import rwl_pkg::*;

  // classified request stream between front and back
  logic  q_valid;
  item_t q_item;
  logic  q_pop;

  rwl_front u_front (
    .clk     (clk),
    .rst     (rst),
    .req     (req),
    .q_valid (q_valid),
    .q_item  (q_item),
    .q_pop   (q_pop)
  );

  rwl_back u_back (
    .clk     (clk),
    .rst     (rst),
    .q_valid (q_valid),
    .q_item  (q_item),
    .q_pop   (q_pop),
    .res     (res)
  );

endmodule

// ----- tb/sv/readers_writer_lock_arbiter_top_test.sv -----
// Self-checking test of the readers-writer lock arbiter with writer preference.
// Depends on rwl_pkg, rwl_req_if, rwl_res_if and readers_writer_lock_arbiter_top;
// a scoreboard class predicts each lock event and checks the result stream.
module readers_writer_lock_arbiter_top_test;
  timeunit 1ns;
  timeprecision 1ps;

  import rwl_pkg::*;

  localparam int RANDOM_ITEMS    = 450;
  localparam int REPORT_LIMIT    = 10;
  localparam int HOLD_OFF_CYCLES = 300;
  localparam int DRAIN_LIMIT     = 20000;
  localparam int SETTLE_CYCLES   = 24;

  // one expected or observed result transfer
  typedef struct packed {
    logic [ID_W-1:0]    thread_id;
    logic [EVENT_W-1:0] event_res;
    logic               last;
  } lock_event_t;

  // traffic shapes for the random part
  typedef enum int {
    SEG_FILL,
    SEG_DRAIN,
    SEG_READ_FLOOD,
    SEG_MIXED
  } seg_kind_t;

  // Shadow copy of the lock: reader count, writer flag and both wait queues.
  // Every accepted request is turned into the events it must cause; every
  // result transfer is compared against the oldest of them.
  class lock_event_board;
    int unsigned     readers_active;
    bit              writer_owns;
    logic [ID_W-1:0] readers_waiting[$];
    logic [ID_W-1:0] writers_waiting[$];
    lock_event_t     pending_events[$];
    lock_event_t     step_events[$];
    int unsigned     mismatches;

    function new();
      readers_active = 0;
      writer_owns    = 1'b0;
      mismatches     = 0;
    endfunction

    function bit lock_idle();
      return readers_active == 0 && !writer_owns &&
             readers_waiting.size() == 0 && writers_waiting.size() == 0;
    endfunction

    function void add_event(logic [ID_W-1:0] id, logic [EVENT_W-1:0] ev);
      step_events.push_back('{thread_id: id, event_res: ev, last: 1'b0});
    endfunction

    function void note_request(logic [MODE_W-1:0] mode, logic [ID_W-1:0] id);
      step_events = {};
      if (int'(id) >= MAX_THREADS) begin
        add_event(id, EV_ERROR);
      end else begin
        case (mode)
          MODE_ENTER_READ: begin
            // a waiting writer blocks new readers
            if (!writer_owns && writers_waiting.size() == 0) begin
              if (readers_active >= READER_MAX) begin
                add_event(id, EV_ERROR);
              end else begin
                readers_active++;
                add_event(id, EV_READ_GRANT);
              end
            end else if (readers_waiting.size() < QUEUE_DEPTH) begin
              readers_waiting.push_back(id);
              add_event(id, EV_QUEUED);
            end else begin
              add_event(id, EV_ERROR);
            end
          end
          MODE_ENTER_WRITE: begin
            if (readers_active == 0 && !writer_owns) begin
              writer_owns = 1'b1;
              add_event(id, EV_WRITE_GRANT);
            end else if (writers_waiting.size() < QUEUE_DEPTH) begin
              writers_waiting.push_back(id);
              add_event(id, EV_QUEUED);
            end else begin
              add_event(id, EV_ERROR);
            end
          end
          MODE_EXIT_READ: begin
            if (readers_active == 0) begin
              add_event(id, EV_ERROR);
            end else begin
              readers_active--;
              // last reader out hands the lock to the oldest writer
              if (readers_active == 0 && writers_waiting.size() != 0) begin
                writer_owns = 1'b1;
                add_event(writers_waiting.pop_front(), EV_WRITER_WOKEN);
              end else begin
                add_event(id, EV_RELEASED);
              end
            end
          end
          MODE_EXIT_WRITE: begin
            if (!writer_owns) begin
              add_event(id, EV_ERROR);
            end else begin
              writer_owns = 1'b0;
              if (readers_waiting.size() != 0) begin
                // wake readers oldest first, bounded by result and reader limits
                while (readers_waiting.size() != 0 && step_events.size() < RESULT_MAX &&
                       readers_active < READER_MAX) begin
                  readers_active++;
                  add_event(readers_waiting.pop_front(), EV_READER_WOKEN);
                end
              end else if (writers_waiting.size() != 0) begin
                writer_owns = 1'b1;
                add_event(writers_waiting.pop_front(), EV_WRITER_WOKEN);
              end else begin
                add_event(id, EV_RELEASED);
              end
            end
          end
        endcase
      end
      step_events[step_events.size() - 1].last = 1'b1;
      foreach (step_events[i]) pending_events.push_back(step_events[i]);
    endfunction

    function void check_result(logic [ID_W-1:0] thread_id, logic [EVENT_W-1:0] event_res,
                               logic last);
      lock_event_t want;
      if (pending_events.size() == 0) begin
        mismatches++;
        if (mismatches <= REPORT_LIMIT)
          $display("%0t: unexpected result thread_id %0d event_res %0d last %0b",
                   $time, thread_id, event_res, last);
      end else begin
        want = pending_events.pop_front();
        if (want.thread_id !== thread_id || want.event_res !== event_res ||
            want.last !== last) begin
          mismatches++;
          if (mismatches <= REPORT_LIMIT) begin
            $write("%0t: result mismatch: expected thread_id %0d event_res %0d last %0b,",
                   $time, want.thread_id, want.event_res, want.last);
            $display(" got thread_id %0d event_res %0d last %0b",
                     thread_id, event_res, last);
          end
        end
      end
    endfunction
  endclass

  logic clk;
  logic rst;

  rwl_req_if req();
  rwl_res_if res();

  readers_writer_lock_arbiter_top i_dut (
    .clk (clk),
    .rst (rst),
    .req (req),
    .res (res)
  );

  lock_event_board board;
  int unsigned     burst_left;
  bit              hold_off_armed;
  bit              hold_off_done;

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // Hard stop well beyond the slowest legal run.
  initial begin
    #6_000_000;
    $display("readers_writer_lock_arbiter_top test failed");
    $finish;
  end

  // Offer one request starting at a falling edge and hold it until the transfer.
  // Bursts of back-to-back requests alternate with random gaps; a zero gap keeps
  // valid high across the burst boundary.
  task automatic offer_request(input logic [MODE_W-1:0] mode, input logic [ID_W-1:0] id);
    int unsigned gap;
    if (burst_left == 0) begin
      gap = $urandom_range(0, 6);
      if (gap != 0) begin
        req.valid <= 1'b0;
        repeat (gap) @(negedge clk);
      end
      burst_left = $urandom_range(1, 12);
    end
    burst_left--;
    req.valid        <= 1'b1;
    req.mode         <= mode;
    req.requester_id <= id;
    do @(posedge clk); while (req.ready !== 1'b1);
    board.note_request(mode, id);
    @(negedge clk);
  endtask

  // Choose a mode for the current traffic shape. Drain traffic releases what is
  // really held and mixed traffic often does; a small share of mixed traffic is pure noise.
  function automatic logic [MODE_W-1:0] pick_mode(seg_kind_t kind);
    int unsigned roll;
    roll = $urandom_range(0, 99);
    case (kind)
      SEG_FILL: begin
        return (roll < 50) ? MODE_ENTER_READ : MODE_ENTER_WRITE;
      end
      SEG_DRAIN: begin
        if (board.writer_owns) return MODE_EXIT_WRITE;
        if (board.readers_active != 0) return MODE_EXIT_READ;
        return MODE_W'($urandom_range(0, 3));
      end
      SEG_READ_FLOOD: begin
        return (roll < 85) ? MODE_ENTER_READ : MODE_EXIT_READ;
      end
      default: begin
        if (roll < 10) return MODE_W'($urandom_range(0, 3));
        if (roll < 45) return MODE_ENTER_READ;
        if (roll < 65) return MODE_ENTER_WRITE;
        if (board.writer_owns) return MODE_EXIT_WRITE;
        return (board.readers_active != 0) ? MODE_EXIT_READ : MODE_EXIT_WRITE;
      end
    endcase
  endfunction

  // Check every result transfer against the oldest expected event.
  always @(posedge clk) begin
    if (rst === 1'b0 && res.valid === 1'b1 && res.ready === 1'b1)
      board.check_result(res.thread_id, res.event_res, res.last);
  end

  // Receiver: spans of full rate, coin-flip and sparse ready, plus one long
  // hold-off once the random part is halfway so the front queue fills and
  // req.ready drops while requests keep coming.
  initial begin
    int unsigned style;
    int unsigned span;
    res.ready <= 1'b0;
    do @(negedge clk); while (rst);
    forever begin
      if (hold_off_armed && !hold_off_done) begin
        res.ready <= 1'b0;
        repeat (HOLD_OFF_CYCLES) @(negedge clk);
        hold_off_done = 1'b1;
      end else begin
        style = $urandom_range(0, 2);
        span  = $urandom_range(10, 60);
        repeat (span) begin
          case (style)
            0:       res.ready <= 1'b1;
            1:       res.ready <= 1'($urandom_range(0, 1));
            default: res.ready <= ($urandom_range(0, 3) == 0);
          endcase
          @(negedge clk);
        end
      end
    end
  end

  // Sender and end of run.
  initial begin
    int unsigned random_left;
    int unsigned seg_idx;
    int unsigned seg_len;
    int unsigned seg_pos;
    int unsigned drain_cycles;
    seg_kind_t   kind;

    board          = new();
    burst_left     = 0;
    hold_off_armed = 1'b0;
    hold_off_done  = 1'b0;
    rst              <= 1'b1;
    req.valid        <= 1'b0;
    req.mode         <= MODE_ENTER_READ;
    req.requester_id <= '0;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // Directed: releases of an unheld lock, every grant, queueing behind a
    // waiting writer, handoff on last reader out, wake of several readers,
    // wake of one writer, and a release that wakes nobody.
    offer_request(MODE_EXIT_READ,   4'd0);
    offer_request(MODE_EXIT_WRITE,  4'd15);
    offer_request(MODE_ENTER_READ,  4'd3);
    offer_request(MODE_ENTER_WRITE, 4'd15);
    offer_request(MODE_ENTER_READ,  4'd0);
    offer_request(MODE_EXIT_READ,   4'd3);
    offer_request(MODE_ENTER_READ,  4'd9);
    offer_request(MODE_ENTER_WRITE, 4'd6);
    offer_request(MODE_EXIT_WRITE,  4'd15);
    offer_request(MODE_EXIT_READ,   4'd0);
    offer_request(MODE_EXIT_READ,   4'd9);
    offer_request(MODE_EXIT_WRITE,  4'd6);
    offer_request(MODE_ENTER_WRITE, 4'd10);
    offer_request(MODE_ENTER_WRITE, 4'd12);
    offer_request(MODE_EXIT_WRITE,  4'd10);
    offer_request(MODE_EXIT_WRITE,  4'd12);
    offer_request(MODE_EXIT_READ,   4'd5);
    offer_request(MODE_ENTER_READ,  4'd15);
    offer_request(MODE_EXIT_READ,   4'd15);

    // Random: fill both wait queues past full, drain them (a full reader queue
    // is woken by one exit write), flood reads past the reader limit, drain
    // again, then mixed traffic; repeat until the item budget is spent.
    seg_idx     = 0;
    random_left = RANDOM_ITEMS;
    while (random_left != 0) begin
      case (seg_idx % 5)
        0: begin kind = SEG_FILL;       seg_len = $urandom_range(36, 42); end
        1: begin kind = SEG_DRAIN;      seg_len = 90;                     end
        2: begin kind = SEG_READ_FLOOD; seg_len = $urandom_range(45, 60); end
        3: begin kind = SEG_DRAIN;      seg_len = 90;                     end
        default: begin kind = SEG_MIXED; seg_len = $urandom_range(30, 60); end
      endcase
      seg_pos = 0;
      // a drain ends as soon as the lock is free and nobody waits
      while (random_left != 0 && seg_pos < seg_len &&
             !(kind == SEG_DRAIN && seg_pos != 0 && board.lock_idle())) begin
        if (random_left == RANDOM_ITEMS / 2) hold_off_armed = 1'b1;
        offer_request(pick_mode(kind), ID_W'($urandom_range(0, MAX_THREADS - 1)));
        seg_pos++;
        random_left--;
      end
      seg_idx++;
    end
    req.valid <= 1'b0;

    // Wait for outstanding results, then idle a little to catch strays.
    drain_cycles = 0;
    while (board.pending_events.size() != 0 && drain_cycles < DRAIN_LIMIT) begin
      @(posedge clk);
      drain_cycles++;
    end
    repeat (SETTLE_CYCLES) @(posedge clk);

    if (board.mismatches == 0 && board.pending_events.size() == 0) begin
      $display("readers_writer_lock_arbiter_top test passed");
    end else begin
      if (board.pending_events.size() != 0)
        $display("%0d expected results never arrived", board.pending_events.size());
      $display("readers_writer_lock_arbiter_top test failed");
    end
    $finish;
  end

endmodule
